// ===== rtl/core/pps_pkg.sv =====
package pps_pkg;

  // Default table size
  localparam int MAX_TASKS_DEF = 16;

  // Field widths fixed by the interface
  localparam int TIME_W = 21;
  localparam int ARR_W  = 16;
  localparam int BUR_W  = 16;
  localparam int PRIO_W = 8;

  // Saturation point of the time counter
  localparam logic [TIME_W-1:0] TIME_MAX = 21'h1FFFFF;

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_ZBURST = 2'd2;

  // One task slot as kept in the task memory
  typedef struct packed {
    logic [ARR_W-1:0]  arrival;
    logic [BUR_W-1:0]  burst;
    logic [BUR_W-1:0]  remain;
    logic [PRIO_W-1:0] prio;
    logic              done;
  } task_entry_t;

  localparam int ENTRY_W = $bits(task_entry_t);

endpackage

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// Load: accepted when idle, result strobed on the next cycle; next beat may follow at once.
// Tick: scans the task memory one slot per cycle through its read port; the result is
//   strobed from the finish state after the scan and update states, and busy drops in
//   that same cycle, so the next tick may be accepted while the result is shown.
// Results are shown for one cycle only; the receiver cannot stall them.
// Reset (synchronous, rst high) clears time and task counts; the memory needs no clearing.
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              req_type,
  input  logic [ARR_W-1:0]  arrival,
  input  logic [BUR_W-1:0]  burst,
  input  logic [PRIO_W-1:0] prio,
  output logic              out_valid,
  output logic [1:0]        status,
  output logic              ran_valid,
  output logic [3:0]        ran_slot,
  output logic              finished,
  output logic [TIME_W-1:0] finish_time,
  output logic [TIME_W-1:0] turnaround,
  output logic [TIME_W-1:0] wait_time,
  output logic              all_done
);

  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  state_t            state;
  logic [TIME_W-1:0] now;
  logic [CNT_W-1:0]  loaded_count;
  logic [CNT_W-1:0]  finished_count;
  logic [CNT_W-1:0]  issue_idx;
  logic              rd_vld;
  logic [SLOT_W-1:0] rd_slot;
  logic              found;
  task_entry_t       best_ent;
  logic [SLOT_W-1:0] best_slot;

  // Memory ports
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  task_entry_t       wr_ent;
  logic [SLOT_W-1:0] rd_addr;
  task_entry_t       rd_ent;
  logic [ENTRY_W-1:0] rd_word;

  // Derived values
  logic              accept;
  logic              load_ok;
  logic              eligible;
  logic              better;
  logic [BUR_W-1:0]  remain_dec;
  logic              fin;
  logic [TIME_W-1:0] now_inc;

  // Low four bits of a slot number, for any slot width
  function automatic logic [3:0] slot4(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+3:0] w;
    w = {4'b0000, s};
    return w[3:0];
  endfunction

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign load_ok = accept && (req_type == REQ_LOAD) && (loaded_count < CNT_MAX)
                   && (burst != '0);

  // Candidate test on the beat coming back from memory
  assign rd_ent   = task_entry_t'(rd_word);
  assign eligible = rd_vld && !rd_ent.done && (rd_ent.remain != '0)
                    && ({5'b00000, rd_ent.arrival} <= now);
  assign better   = !found || (rd_ent.prio < best_ent.prio)
                    || ((rd_ent.prio == best_ent.prio) && (rd_ent.arrival < best_ent.arrival));

  assign remain_dec = best_ent.remain - BUR_W'(1);
  assign fin        = found && (remain_dec == '0);
  assign now_inc    = (now == TIME_MAX) ? now : now + TIME_W'(1);

  // Write port: new task on load, served task on update
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = loaded_count[SLOT_W-1:0];
    wr_ent  = '{arrival: arrival, burst: burst, remain: burst, prio: prio, done: 1'b0};
    if (state == ST_UPDATE) begin
      wr_en   = found;
      wr_addr = best_slot;
      wr_ent  = best_ent;
      wr_ent.remain = remain_dec;
      wr_ent.done   = (remain_dec == '0);
    end else if (load_ok) begin
      wr_en = 1'b1;
    end
  end

  assign rd_addr = issue_idx[SLOT_W-1:0];

  pps_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_TASKS)
  ) u_task_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(ENTRY_W'(wr_ent)),
    .rd_addr(rd_addr),
    .rd_data(rd_word)
  );

  // Sequencer, counters and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      now            <= '0;
      loaded_count   <= '0;
      finished_count <= '0;
      out_valid      <= 1'b0;
      rd_vld         <= 1'b0;
      found          <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req_type == REQ_LOAD) begin
              out_valid   <= 1'b1;
              ran_valid   <= 1'b0;
              finished    <= 1'b0;
              finish_time <= '0;
              turnaround  <= '0;
              wait_time   <= '0;
              ran_slot    <= 4'd0;
              all_done    <= (finished_count == loaded_count);
              if (loaded_count >= CNT_MAX) begin
                status <= STAT_FULL;
              end else if (burst == '0) begin
                status <= STAT_ZBURST;
              end else begin
                status       <= STAT_OK;
                ran_slot     <= slot4(loaded_count[SLOT_W-1:0]);
                loaded_count <= loaded_count + CNT_W'(1);
                all_done     <= 1'b0;
              end
            end else begin
              state     <= ST_SCAN;
              issue_idx <= '0;
              found     <= 1'b0;
              rd_vld    <= 1'b0;
            end
          end
        end

        ST_SCAN: begin
          // issue one read per cycle, compare the beat returned from the previous one
          if (issue_idx < loaded_count) begin
            rd_vld    <= 1'b1;
            rd_slot   <= issue_idx[SLOT_W-1:0];
            issue_idx <= issue_idx + CNT_W'(1);
          end else begin
            rd_vld <= 1'b0;
            if (!rd_vld) begin
              state <= ST_UPDATE;
            end
          end
          if (eligible && better) begin
            found     <= 1'b1;
            best_ent  <= rd_ent;
            best_slot <= rd_slot;
          end
        end

        ST_UPDATE: begin
          now         <= now_inc;
          status      <= STAT_OK;
          ran_valid   <= found;
          ran_slot    <= found ? slot4(best_slot) : 4'd0;
          finished    <= fin;
          finish_time <= fin ? now_inc : '0;
          turnaround  <= fin ? now_inc - {5'b00000, best_ent.arrival} : '0;
          if (fin) begin
            finished_count <= finished_count + CNT_W'(1);
          end
          state <= ST_FINISH;
        end

        ST_FINISH: begin
          // wait time saturates at zero
          if (finished && (turnaround >= {5'b00000, best_ent.burst})) begin
            wait_time <= turnaround - {5'b00000, best_ent.burst};
          end else begin
            wait_time <= '0;
          end
          all_done  <= (finished_count == loaded_count);
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/pps_ram.sv =====
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1430;
  localparam int BIG_LOAD_AT = 1100;
  localparam int CALM_FROM = 400;
  localparam int CALM_TO = 700;

  typedef struct packed {
    logic              rq;
    logic [ARR_W-1:0]  arr;
    logic [BUR_W-1:0]  bur;
    logic [PRIO_W-1:0] pr;
  } sched_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              ran;
    logic [3:0]        slot;
    logic              fin;
    logic [TIME_W-1:0] ftime;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    logic              all_done;
  } sched_res_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              req_type = REQ_TICK;
  logic [ARR_W-1:0]  arrival = '0;
  logic [BUR_W-1:0]  burst = '0;
  logic [PRIO_W-1:0] prio = '0;
  logic              out_valid;
  logic [1:0]        status;
  logic              ran_valid;
  logic [3:0]        ran_slot;
  logic              finished;
  logic [TIME_W-1:0] finish_time;
  logic [TIME_W-1:0] turnaround;
  logic [TIME_W-1:0] wait_time;
  logic              all_done;

  preemptive_priority_scheduler dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .arrival(arrival), .burst(burst), .prio(prio),
    .out_valid(out_valid), .status(status), .ran_valid(ran_valid),
    .ran_slot(ran_slot), .finished(finished), .finish_time(finish_time),
    .turnaround(turnaround), .wait_time(wait_time), .all_done(all_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Requests waiting to be driven, results waiting to be seen
  sched_req_t pending_reqs[$];
  sched_res_t expected_outcomes[$];
  int fail_count = 0;
  int beat_cnt = 0;
  int cycle_cnt = 0;

  // Scheduler shadow state
  logic [ARR_W-1:0]  task_arr[MAX_TASKS_DEF];
  logic [BUR_W-1:0]  task_bur[MAX_TASKS_DEF];
  logic [BUR_W-1:0]  task_rem[MAX_TASKS_DEF];
  logic [PRIO_W-1:0] task_prio[MAX_TASKS_DEF];
  logic              task_done[MAX_TASKS_DEF];
  logic [TIME_W-1:0] sched_now = '0;
  int n_loaded = 0;
  int n_finished = 0;

  // Generator's own view of time and table fill, to shape the stimulus
  int gen_now = 0;
  int gen_loaded = 0;

  // Apply one accepted beat to the shadow state and queue its outcome
  task automatic advance_scheduler(input sched_req_t r);
    sched_res_t e;
    int best;
    bit found;
    logic [TIME_W-1:0] tat;
    e = '0;
    if (r.rq == REQ_LOAD) begin
      if (n_loaded >= MAX_TASKS_DEF) begin
        e.status = STAT_FULL;
      end else if (r.bur == '0) begin
        e.status = STAT_ZBURST;
      end else begin
        task_arr[n_loaded] = r.arr;
        task_bur[n_loaded] = r.bur;
        task_rem[n_loaded] = r.bur;
        task_prio[n_loaded] = r.pr;
        task_done[n_loaded] = 1'b0;
        e.slot = 4'(n_loaded);
        n_loaded++;
      end
    end else begin
      best = 0;
      found = 1'b0;
      // smallest prio, then earliest arrival, then lowest slot
      for (int i = 0; i < n_loaded; i++) begin
        if (task_done[i] || task_rem[i] == '0 || TIME_W'(task_arr[i]) > sched_now) continue;
        if (!found || task_prio[i] < task_prio[best] ||
            (task_prio[i] == task_prio[best] && task_arr[i] < task_arr[best])) begin
          best = i;
          found = 1'b1;
        end
      end
      if (sched_now < TIME_MAX) sched_now = sched_now + 1'b1;
      if (found) begin
        e.ran = 1'b1;
        e.slot = 4'(best);
        task_rem[best] = task_rem[best] - 1'b1;
        if (task_rem[best] == '0) begin
          task_done[best] = 1'b1;
          n_finished++;
          tat = sched_now - TIME_W'(task_arr[best]);
          e.fin = 1'b1;
          e.ftime = sched_now;
          e.tat = tat;
          e.wt = (tat >= TIME_W'(task_bur[best])) ? tat - TIME_W'(task_bur[best]) : '0;
        end
      end
    end
    e.all_done = (n_finished == n_loaded);
    expected_outcomes.insert(expected_outcomes.size(), e);
  endtask

  function automatic void queue_load(input int a, input int b, input int p);
    sched_req_t r;
    r.rq = REQ_LOAD;
    r.arr = ARR_W'(a);
    r.bur = BUR_W'(b);
    r.pr = PRIO_W'(p);
    if (gen_loaded < MAX_TASKS_DEF && b != 0) gen_loaded++;
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Tick beats carry junk in the unused fields
  function automatic void queue_tick();
    sched_req_t r;
    r.rq = REQ_TICK;
    r.arr = ARR_W'($urandom);
    r.bur = BUR_W'($urandom);
    r.pr = PRIO_W'($urandom);
    gen_now++;
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Driver: present the next beat once the previous one is taken
  always @(posedge clk) begin : driver
    sched_req_t nxt;
    bit quiet;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        advance_scheduler({req_type, arrival, burst, prio});
        beat_cnt++;
      end
      if (!start || !busy) begin
        quiet = (beat_cnt < CALM_FROM || beat_cnt >= CALM_TO) && ($urandom_range(0, 99) < 37);
        if (pending_reqs.size() > 0 && !quiet) begin
          nxt = pending_reqs.pop_front();
          start <= 1'b1;
          req_type <= nxt.rq;
          arrival <= nxt.arr;
          burst <= nxt.bur;
          prio <= nxt.pr;
        end else begin
          start <= 1'b0;
          req_type <= 1'($urandom);
          arrival <= ARR_W'($urandom);
          burst <= BUR_W'($urandom);
          prio <= PRIO_W'($urandom);
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation
  always @(posedge clk) begin : monitor
    sched_res_t got;
    sched_res_t want;
    if (!rst && out_valid) begin
      got = {status, ran_valid, ran_slot, finished, finish_time, turnaround, wait_time,
             all_done};
      if (expected_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = expected_outcomes.pop_front();
        if (got.status !== want.status || got.ran !== want.ran ||
            got.slot !== want.slot || got.fin !== want.fin ||
            got.ftime !== want.ftime || got.tat !== want.tat ||
            got.wt !== want.wt || got.all_done !== want.all_done) begin
          fail_count++;
          if (fail_count <= 10) $display("result mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Hard stop
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int roll;
    int a;
    // Directed: empty table, rejects, tie breaks, late loads, idle ticks
    queue_tick();                 // idle with nothing loaded
    queue_load(65535, 0, 255);    // zero burst rejected
    queue_load(0, 1, 255);
    queue_tick();                 // finishes slot 0
    queue_tick();                 // idle after everything done
    queue_load(5, 2, 5);          // arrives in the future
    queue_tick();
    queue_tick();
    queue_tick();
    queue_load(0, 3, 5);          // late load, same prio, earlier arrival
    queue_load(0, 1, 5);          // full tie, lower slot wins
    queue_load(0, 1, 0);          // top priority preempts
    repeat (8) queue_tick();

    // Random: mostly ticks, a sprinkling of loads, zero-burst rejects and loads into a full table
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      roll = $urandom_range(0, 999);
      if (i == BIG_LOAD_AT && gen_loaded < MAX_TASKS_DEF) begin
        queue_load(0, 65535, 255);  // never finishes; soaks up idle ticks
      end else if (gen_loaded < MAX_TASKS_DEF - 1 && roll < 20) begin
        if ($urandom_range(0, 1) == 1 && gen_now > 0)
          a = gen_now - $urandom_range(0, gen_now < 30 ? gen_now : 30);
        else
          a = gen_now + $urandom_range(0, 40);
        queue_load(a, $urandom_range(1, 25),
                   $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
      end else if (roll < 35) begin
        queue_load($urandom_range(0, 65535), 0, $urandom_range(0, 255));
      end else if (gen_loaded >= MAX_TASKS_DEF && roll < 90) begin
        queue_load($urandom_range(0, 65535),
                   $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535),
                   $urandom_range(0, 255));
      end else begin
        queue_tick();
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || start) @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_outcomes.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
